### hw/rtl/srg_pkg.sv
// Shared types, constants and helpers for the stepper speed ramp generator.
package srg_pkg;

    // Default input clock, divided by 16 for the timer
    localparam int unsigned CLOCK_HZ_DEF = 16000000;

    // Widths of the serial datapath and of the work values
    localparam int DIV_W  = 24;
    localparam int MUL_W  = 12;
    localparam int CNT_W  = $clog2(DIV_W);
    localparam int PER_W  = 16;
    localparam int FREQ_W = 16;
    localparam int RPM_W  = 10;

    // Seconds per minute, divisor for step frequency
    localparam logic [DIV_W-1:0] SEC_PER_MIN = DIV_W'(60);

    // Command kinds
    localparam logic [2:0] KIND_TICK = 3'd0;
    localparam logic [2:0] KIND_RAMP = 3'd1;
    localparam logic [2:0] KIND_MOVE = 3'd2;
    localparam logic [2:0] KIND_STOP = 3'd3;
    localparam logic [2:0] KIND_RUN  = 3'd4;

    // Microstep setting codes
    localparam logic [2:0] MS_FULL      = 3'd0;
    localparam logic [2:0] MS_HALF      = 3'd1;
    localparam logic [2:0] MS_QUARTER   = 3'd2;
    localparam logic [2:0] MS_EIGHTH    = 3'd3;
    localparam logic [2:0] MS_SIXTEENTH = 3'd4;

    // Motion modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_ACC  = 2'd1;
    localparam logic [1:0] MODE_DEC  = 2'd2;
    localparam logic [1:0] MODE_POS  = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [9:0]  speed_rpm;
        logic [7:0]  ramp_seconds;
        logic [14:0] step_target;
        logic        direction;
    } srg_in_t;

    typedef struct packed {
        logic [15:0] period;
        logic        running;
        logic        step_level;
        logic [1:0]  motion_mode;
        logic        ramp_busy;
        logic        dir_out;
        logic        status;
    } srg_out_t;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } alu_op_t;

    typedef struct packed {
        logic             start;
        alu_op_t          op;
        logic [DIV_W-1:0] opa;
        logic [DIV_W-1:0] opb;
    } alu_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] result;
    } alu_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FMUL,
        S_FDIV,
        S_PDIV,
        S_PWB,
        S_SMUL,
        S_SDIV,
        S_DONE
    } core_state_t;

    // Steps per revolution for a microstep setting; unused codes act as sixteenth
    function automatic logic [MUL_W-1:0] steps_per_rev(input logic [2:0] mode);
        logic [MUL_W-1:0] spr;
        case (mode)
            MS_FULL:    spr = MUL_W'(200);
            MS_HALF:    spr = MUL_W'(400);
            MS_QUARTER: spr = MUL_W'(800);
            MS_EIGHTH:  spr = MUL_W'(1600);
            default:    spr = MUL_W'(3200);
        endcase
        return spr;
    endfunction

endpackage

### hw/rtl/srg_serial_unit.sv
// Bit-serial shift-add multiplier and restoring divider, one bit per cycle.
module srg_serial_unit
    import srg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    alu_op_t          op_reg, op_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] acc_reg, acc_next;
    logic [DIV_W-1:0] sha_reg, sha_next;
    logic [DIV_W-1:0] shb_reg, shb_next;

    logic [DIV_W:0]   rem_shift;
    logic [DIV_W:0]   rem_diff;

    // Shift the next dividend bit into the partial remainder
    assign rem_shift = {acc_reg, sha_reg[DIV_W-1]};
    assign rem_diff  = rem_shift - {1'b0, shb_reg};

    // Advance one bit of the running operation
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        sha_next  = sha_reg;
        shb_next  = shb_reg;
        if (busy_reg)
        begin
            if (op_reg == OP_MUL)
            begin
                if (shb_reg[0])
                begin
                    acc_next = acc_reg + sha_reg;
                end
                sha_next = {sha_reg[DIV_W-2:0], 1'b0};
                shb_next = {1'b0, shb_reg[DIV_W-1:1]};
            end
            else
            begin
                if (!rem_diff[DIV_W])
                begin
                    acc_next = rem_diff[DIV_W-1:0];
                    sha_next = {sha_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    acc_next = rem_shift[DIV_W-1:0];
                    sha_next = {sha_reg[DIV_W-2:0], 1'b0};
                end
            end
            if (cnt_reg == CNT_W'(0))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            acc_next  = '0;
            sha_next  = req.opa;
            shb_next  = req.opb;
            cnt_next  = (req.op == OP_MUL) ? CNT_W'(MUL_W - 1) : CNT_W'(DIV_W - 1);
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Hold operands and partial results
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        sha_reg <= sha_next;
        shb_reg <= shb_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = (op_reg == OP_MUL) ? acc_reg : sha_reg;

endmodule

### hw/rtl/srg_core.sv
// Command sequencer and motion state of the stepper speed ramp generator.
module srg_core
    import srg_pkg::*;
#(
    parameter int unsigned CLOCK_HZ = CLOCK_HZ_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  srg_in_t    item,
    input  logic [2:0] microstep_mode,
    output logic       idle,
    output logic       res_valid,
    input  logic       res_ready,
    output srg_out_t   result
);

    localparam logic [DIV_W-1:0] TIMER_HZ = DIV_W'(CLOCK_HZ / 16);

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    srg_serial_unit u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    core_state_t       state_reg, state_next;
    logic              pass_reg, pass_next;
    logic [2:0]        kind_reg, kind_next;
    logic [RPM_W-1:0]  rpm_reg, rpm_next;
    logic [7:0]        secs_reg, secs_next;
    logic              cdir_reg, cdir_next;
    logic [FREQ_W-1:0] f_new_reg, f_new_next;
    logic [FREQ_W-1:0] f_last_reg, f_last_next;
    logic [PER_W-1:0]  per_reg, per_next;
    logic              status_reg, status_next;

    logic [PER_W-1:0]  period_now_reg, period_now_next;
    logic [PER_W-1:0]  period_goal_reg, period_goal_next;
    logic [PER_W-1:0]  period_step_reg, period_step_next;
    logic [RPM_W-1:0]  last_rpm_reg, last_rpm_next;
    logic [RPM_W-1:0]  pending_rpm_reg, pending_rpm_next;
    logic [1:0]        mode_reg, mode_next;
    logic              ramping_reg, ramping_next;
    logic              timer_on_reg, timer_on_next;
    logic              pin_level_reg, pin_level_next;
    logic              dir_reg, dir_next;
    logic [15:0]       edge_count_reg, edge_count_next;
    logic [15:0]       edge_goal_reg, edge_goal_next;
    logic              positioning_reg, positioning_next;

    logic [PER_W-1:0]  diff_dn;
    logic [PER_W-1:0]  diff_up;
    logic [15:0]       edge_inc;
    logic [DIV_W-1:0]  quot_m1;
    logic [PER_W-1:0]  per_of_quot;
    logic              speeding;
    logic [PER_W-1:0]  ramp_dist;
    logic [FREQ_W-1:0] freq_base;

    // Distances between current and goal period, both ways
    assign diff_dn  = period_now_reg - period_goal_reg;
    assign diff_up  = period_goal_reg - period_now_reg;
    assign edge_inc = edge_count_reg + 16'd1;

    // Turn a timer quotient into a compare period, saturated to 16 bits
    assign quot_m1 = alu_rsp.result - DIV_W'(1);
    always_comb
    begin
        if (alu_rsp.result == '0)
        begin
            per_of_quot = '0;
        end
        else if (quot_m1[DIV_W-1:PER_W] != '0)
        begin
            per_of_quot = '1;
        end
        else
        begin
            per_of_quot = quot_m1[PER_W-1:0];
        end
    end

    // Pick ramp direction, distance and base frequency
    assign speeding  = (last_rpm_reg < rpm_reg);
    assign freq_base = speeding ? f_new_reg : f_last_reg;
    always_comb
    begin
        if (speeding)
        begin
            ramp_dist = (period_now_reg >= period_goal_reg) ? diff_dn : '0;
        end
        else
        begin
            ramp_dist = (period_goal_reg >= period_now_reg) ? diff_up : '0;
        end
    end

    // Sequence commands through the serial unit
    always_comb
    begin
        state_next       = state_reg;
        pass_next        = pass_reg;
        kind_next        = kind_reg;
        rpm_next         = rpm_reg;
        secs_next        = secs_reg;
        cdir_next        = cdir_reg;
        f_new_next       = f_new_reg;
        f_last_next      = f_last_reg;
        per_next         = per_reg;
        status_next      = status_reg;
        period_now_next  = period_now_reg;
        period_goal_next = period_goal_reg;
        period_step_next = period_step_reg;
        last_rpm_next    = last_rpm_reg;
        pending_rpm_next = pending_rpm_reg;
        mode_next        = mode_reg;
        ramping_next     = ramping_reg;
        timer_on_next    = timer_on_reg;
        pin_level_next   = pin_level_reg;
        dir_next         = dir_reg;
        edge_count_next  = edge_count_reg;
        edge_goal_next   = edge_goal_reg;
        positioning_next = positioning_reg;
        alu_req.start    = 1'b0;
        alu_req.op       = OP_MUL;
        alu_req.opa      = '0;
        alu_req.opb      = '0;
        res_valid        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next   = item.kind;
                    rpm_next    = item.speed_rpm;
                    secs_next   = item.ramp_seconds;
                    cdir_next   = item.direction;
                    pass_next   = 1'b0;
                    status_next = 1'b0;
                    state_next  = S_DONE;
                    case (item.kind)
                        KIND_TICK:
                        begin
                            if (timer_on_reg)
                            begin
                                pin_level_next = !pin_level_reg;
                                if (ramping_reg && mode_reg == MODE_ACC)
                                begin
                                    if (period_now_reg <= period_goal_reg ||
                                        period_step_reg == '0 ||
                                        diff_dn <= period_step_reg)
                                    begin
                                        period_now_next = period_goal_reg;
                                        last_rpm_next   = pending_rpm_reg;
                                        ramping_next    = 1'b0;
                                    end
                                    else
                                    begin
                                        period_now_next = period_now_reg - period_step_reg;
                                    end
                                end
                                else if (ramping_reg && mode_reg == MODE_DEC)
                                begin
                                    if (period_now_reg >= period_goal_reg ||
                                        period_step_reg == '0 ||
                                        diff_up <= period_step_reg)
                                    begin
                                        period_now_next = period_goal_reg;
                                        last_rpm_next   = pending_rpm_reg;
                                        ramping_next    = 1'b0;
                                    end
                                    else
                                    begin
                                        period_now_next = period_now_reg + period_step_reg;
                                    end
                                end
                                if (mode_reg == MODE_POS && positioning_reg)
                                begin
                                    edge_count_next = edge_inc;
                                    if (edge_inc >= edge_goal_reg)
                                    begin
                                        timer_on_next    = 1'b0;
                                        mode_next        = MODE_IDLE;
                                        ramping_next     = 1'b0;
                                        positioning_next = 1'b0;
                                    end
                                end
                            end
                        end
                        KIND_RAMP:
                        begin
                            if (ramping_reg)
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                alu_req.start = 1'b1;
                                alu_req.opa   = DIV_W'(item.speed_rpm);
                                alu_req.opb   = DIV_W'(steps_per_rev(microstep_mode));
                                state_next    = S_FMUL;
                            end
                        end
                        KIND_MOVE:
                        begin
                            edge_goal_next   = {item.step_target, 1'b0};
                            edge_count_next  = '0;
                            positioning_next = 1'b1;
                            timer_on_next    = 1'b1;
                            mode_next        = MODE_POS;
                            dir_next         = item.direction;
                            alu_req.start    = 1'b1;
                            alu_req.opa      = DIV_W'(item.speed_rpm);
                            alu_req.opb      = DIV_W'(steps_per_rev(microstep_mode));
                            state_next       = S_FMUL;
                        end
                        KIND_RUN:
                        begin
                            timer_on_next = 1'b1;
                            dir_next      = item.direction;
                            alu_req.start = 1'b1;
                            alu_req.opa   = DIV_W'(item.speed_rpm);
                            alu_req.opb   = DIV_W'(steps_per_rev(microstep_mode));
                            state_next    = S_FMUL;
                        end
                        KIND_STOP:
                        begin
                            timer_on_next    = 1'b0;
                            mode_next        = MODE_IDLE;
                            ramping_next     = 1'b0;
                            positioning_next = 1'b0;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // Steps per minute done; divide down to steps per second
            S_FMUL:
            begin
                if (alu_rsp.done)
                begin
                    alu_req.start = 1'b1;
                    alu_req.op    = OP_DIV;
                    alu_req.opa   = alu_rsp.result;
                    alu_req.opb   = SEC_PER_MIN;
                    state_next    = S_FDIV;
                end
            end

            // Frequency known; divide the timer clock by it
            S_FDIV:
            begin
                if (alu_rsp.done)
                begin
                    if (pass_reg)
                    begin
                        f_last_next = alu_rsp.result[FREQ_W-1:0];
                    end
                    else
                    begin
                        f_new_next = alu_rsp.result[FREQ_W-1:0];
                    end
                    if (alu_rsp.result[FREQ_W-1:0] == '0)
                    begin
                        per_next   = '1;
                        state_next = S_PWB;
                    end
                    else
                    begin
                        alu_req.start = 1'b1;
                        alu_req.op    = OP_DIV;
                        alu_req.opa   = TIMER_HZ;
                        alu_req.opb   = DIV_W'(alu_rsp.result[FREQ_W-1:0]);
                        state_next    = S_PDIV;
                    end
                end
            end

            S_PDIV:
            begin
                if (alu_rsp.done)
                begin
                    per_next   = per_of_quot;
                    state_next = S_PWB;
                end
            end

            // Write the period back; a ramp goes on to the last speed and the step
            S_PWB:
            begin
                if (kind_reg == KIND_RAMP)
                begin
                    alu_req.start = 1'b1;
                    if (!pass_reg)
                    begin
                        period_goal_next = per_reg;
                        pass_next        = 1'b1;
                        alu_req.opa      = DIV_W'(last_rpm_reg);
                        alu_req.opb      = DIV_W'(steps_per_rev(microstep_mode));
                        state_next       = S_FMUL;
                    end
                    else
                    begin
                        period_now_next = per_reg;
                        alu_req.opa     = DIV_W'(freq_base);
                        alu_req.opb     = DIV_W'(secs_reg);
                        state_next      = S_SMUL;
                    end
                end
                else
                begin
                    period_now_next = per_reg;
                    state_next      = S_DONE;
                end
            end

            // Ramp tick count known; divide the period distance by it
            S_SMUL:
            begin
                if (alu_rsp.done)
                begin
                    alu_req.start = 1'b1;
                    alu_req.op    = OP_DIV;
                    alu_req.opa   = DIV_W'(ramp_dist);
                    alu_req.opb   = (alu_rsp.result == '0) ? DIV_W'(1) : alu_rsp.result;
                    state_next    = S_SDIV;
                end
            end

            S_SDIV:
            begin
                if (alu_rsp.done)
                begin
                    period_step_next = alu_rsp.result[PER_W-1:0];
                    pending_rpm_next = rpm_reg;
                    mode_next        = speeding ? MODE_ACC : MODE_DEC;
                    ramping_next     = 1'b1;
                    timer_on_next    = 1'b1;
                    dir_next         = cdir_reg;
                    state_next       = S_DONE;
                end
            end

            // Offer the result until the output side takes it
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold sequencer and motion state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            pass_reg        <= 1'b0;
            status_reg      <= 1'b0;
            period_now_reg  <= '0;
            period_goal_reg <= '0;
            period_step_reg <= '0;
            last_rpm_reg    <= RPM_W'(6);
            pending_rpm_reg <= '0;
            mode_reg        <= MODE_IDLE;
            ramping_reg     <= 1'b0;
            timer_on_reg    <= 1'b0;
            pin_level_reg   <= 1'b0;
            dir_reg         <= 1'b0;
            edge_count_reg  <= '0;
            edge_goal_reg   <= '0;
            positioning_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pass_reg        <= pass_next;
            status_reg      <= status_next;
            period_now_reg  <= period_now_next;
            period_goal_reg <= period_goal_next;
            period_step_reg <= period_step_next;
            last_rpm_reg    <= last_rpm_next;
            pending_rpm_reg <= pending_rpm_next;
            mode_reg        <= mode_next;
            ramping_reg     <= ramping_next;
            timer_on_reg    <= timer_on_next;
            pin_level_reg   <= pin_level_next;
            dir_reg         <= dir_next;
            edge_count_reg  <= edge_count_next;
            edge_goal_reg   <= edge_goal_next;
            positioning_reg <= positioning_next;
        end
    end

    // Hold the command operands and intermediate values
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        rpm_reg    <= rpm_next;
        secs_reg   <= secs_next;
        cdir_reg   <= cdir_next;
        f_new_reg  <= f_new_next;
        f_last_reg <= f_last_next;
        per_reg    <= per_next;
    end

    assign idle = (state_reg == S_IDLE);

    assign result.period      = period_now_reg;
    assign result.running     = timer_on_reg;
    assign result.step_level  = pin_level_reg;
    assign result.motion_mode = mode_reg;
    assign result.ramp_busy   = ramping_reg;
    assign result.dir_out     = dir_reg;
    assign result.status      = status_reg;

endmodule

### hw/rtl/stepper_speed_ramp_generator.sv
// Top level of the stepper speed ramp generator: channels, setting register, result register.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_data   (srg_in_t)
//   out      output     out_valid/out_stall  out_data  (srg_out_t)
//   cfg      input      cfg_valid/cfg_ready  cfg_data  (microstep mode)
//
// From one input transfer to the next: a tick, stop or unused kind goes straight to its
// result, a run or move command through a multiply and two divides, and a ramp command
// (if no ramp runs) these twice plus a multiply and a divide for its step. All frequency,
// period and step work uses the bit-serial unit; a zero frequency skips the period divide.
// One item is worked at a time; the next is taken once the result sits in the
// output register. Reset is asynchronous, active low; cfg_ready is always high.
module stepper_speed_ramp_generator
    import srg_pkg::*;
#(
    parameter int unsigned CLOCK_HZ = CLOCK_HZ_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  srg_in_t    in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output srg_out_t   out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_data
);

    logic       core_idle;
    logic       res_valid;
    logic       res_ready;
    srg_out_t   core_result;
    logic [2:0] microstep_reg;
    logic       out_valid_reg;
    srg_out_t   out_data_reg;

    srg_core #(
        .CLOCK_HZ (CLOCK_HZ)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (in_valid && !in_stall),
        .item           (in_data),
        .microstep_mode (microstep_reg),
        .idle           (core_idle),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .result         (core_result)
    );

    assign in_stall  = !core_idle;
    assign cfg_ready = 1'b1;

    // Free output slot: empty, or being taken this cycle
    assign res_ready = !out_valid_reg || !out_stall;

    // Take the microstep setting on a transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            microstep_reg <= MS_FULL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            microstep_reg <= cfg_data;
        end
    end

    // Load the result register; drop valid after a transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= core_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
